/* rtl/kvt_pkg.sv */
// Shared types and constants for the key/value tokenizer.
// Holds the beat structs, the configuration bundle, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  // One input beat: a data byte, or an end-of-buffer command.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic        text_valid;
    logic [7:0]  text_byte;
    logic [1:0]  segment;
    logic        field_end;
    logic [15:0] field_number;
    logic [1:0]  pair_seps_seen;
    logic        record_end;
    logic        empty_key_error;
  } out_item_t;

  // Configuration registers, as seen by the tokenizer core.
  typedef struct packed {
    logic [7:0] field_sep;
    logic [7:0] pair_sep;
    logic [7:0] record_sep;
    logic       collapse_repeats;
  } cfg_t;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIELD_SEP        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PAIR_SEP         = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RECORD_SEP       = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLLAPSE_REPEATS = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] FIELD_SEP_RESET        = 8'd44;
  localparam logic [7:0] PAIR_SEP_RESET         = 8'd61;
  localparam logic [7:0] RECORD_SEP_RESET       = 8'd10;
  localparam logic       COLLAPSE_REPEATS_RESET = 1'b0;

  // The command code that ends the buffer.
  localparam logic CMD_END_OF_BUFFER = 1'b1;

  // Width of the field number on the result beat.
  localparam int FIELD_NUMBER_OUT_BITS = 16;

endpackage : kvt_pkg

`default_nettype wire

/* rtl/kvt_cfg.sv */
// Configuration register file of the key/value tokenizer.
// Depends on kvt_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module kvt_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [kvt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [kvt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output kvt_pkg::cfg_t                           cfg
);

  kvt_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.field_sep        <= kvt_pkg::FIELD_SEP_RESET;
      regs.pair_sep         <= kvt_pkg::PAIR_SEP_RESET;
      regs.record_sep       <= kvt_pkg::RECORD_SEP_RESET;
      regs.collapse_repeats <= kvt_pkg::COLLAPSE_REPEATS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kvt_pkg::CFG_FIELD_SEP:        regs.field_sep        <= cfg_data;
        kvt_pkg::CFG_PAIR_SEP:         regs.pair_sep         <= cfg_data;
        kvt_pkg::CFG_RECORD_SEP:       regs.record_sep       <= cfg_data;
        kvt_pkg::CFG_COLLAPSE_REPEATS: regs.collapse_repeats <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule : kvt_cfg

`default_nettype wire

/* rtl/kvt_core.sv */
// Tokenizer core: per-field state registers and the classification logic for one byte.
// Depends on kvt_pkg for in_item_t, out_item_t, cfg_t and the command code.
`timescale 1ns / 1ps
`default_nettype none

module kvt_core #(
  parameter int CNT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire kvt_pkg::in_item_t item,
  input  wire kvt_pkg::cfg_t     cfg,
  output kvt_pkg::out_item_t     result
);

  logic [CNT_BITS-1:0] field_counter, field_counter_next;
  logic [1:0]          pair_sep_counter, pair_sep_counter_next;
  logic                key_has_text, key_has_text_next;
  logic                skipping_repeats, skipping_repeats_next;

  logic                is_record, is_field, is_pair;
  logic [CNT_BITS-1:0] closed_number;

  // Field number of a field that closes now; it holds at all ones.
  assign closed_number = (field_counter == {CNT_BITS{1'b1}}) ? field_counter
                                                              : field_counter + CNT_BITS'(1);

  always_comb begin
    is_record = (item.cmd == kvt_pkg::CMD_END_OF_BUFFER) || (item.data_byte == cfg.record_sep);
    is_field  = item.data_byte == cfg.field_sep;
    is_pair   = item.data_byte == cfg.pair_sep;

    field_counter_next    = field_counter;
    pair_sep_counter_next = pair_sep_counter;
    key_has_text_next     = key_has_text;
    skipping_repeats_next = skipping_repeats;
    result                = '0;

    if (is_record || (is_field && !skipping_repeats)) begin
      // Close the current field.
      result.field_end       = 1'b1;
      result.field_number    = kvt_pkg::FIELD_NUMBER_OUT_BITS'(closed_number);
      result.pair_seps_seen  = pair_sep_counter;
      result.empty_key_error = !key_has_text;
      result.record_end      = is_record;
      pair_sep_counter_next  = '0;
      key_has_text_next      = 1'b0;
      if (is_record) begin
        field_counter_next    = '0;
        skipping_repeats_next = 1'b0;
      end else begin
        field_counter_next    = closed_number;
        skipping_repeats_next = cfg.collapse_repeats;
      end
    end else if (is_field) begin
      // A repeated field separator is dropped; the result stays all zero.
    end else if (is_pair) begin
      skipping_repeats_next = 1'b0;
      if (pair_sep_counter != 2'd3) begin
        pair_sep_counter_next = pair_sep_counter + 2'd1;
      end
    end else begin
      skipping_repeats_next = 1'b0;
      if (pair_sep_counter == 2'd0) begin
        key_has_text_next = 1'b1;
      end
      result.text_valid = 1'b1;
      result.text_byte  = item.data_byte;
      result.segment    = pair_sep_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_counter    <= '0;
      pair_sep_counter <= '0;
      key_has_text     <= 1'b0;
      skipping_repeats <= 1'b0;
    end else if (accept) begin
      field_counter    <= field_counter_next;
      pair_sep_counter <= pair_sep_counter_next;
      key_has_text     <= key_has_text_next;
      skipping_repeats <= skipping_repeats_next;
    end
  end

endmodule : kvt_core

`default_nettype wire

/* rtl/kvt_skid.sv */
// Two-entry output buffer for result beats, so the input side keeps moving one stall deep.
// Depends on kvt_pkg for out_item_t.
`timescale 1ns / 1ps
`default_nettype none

module kvt_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire kvt_pkg::out_item_t din,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output kvt_pkg::out_item_t      out_data
);

  kvt_pkg::out_item_t main_data, skid_data;
  logic               main_valid, skid_valid;
  logic               pop;

  assign pop       = main_valid && out_ready;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      // The waiting beat moves up; no push can happen while the skid entry is full.
      main_data  <= skid_data;
      skid_valid <= 1'b0;
    end else if (push && (!main_valid || pop)) begin
      main_data  <= din;
      main_valid <= 1'b1;
    end else if (push) begin
      skid_data  <= din;
      skid_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule : kvt_skid

`default_nettype wire

/* rtl/key_value_pair_tokenizer.sv */
// Top level of the delimited key/value tokenizer.
// Depends on kvt_pkg, kvt_cfg, kvt_core and kvt_skid.
//
// Usage:
// The input channel (in_valid, in_ready, in_data) carries one beat per byte of a
// delimited text buffer, or an end-of-buffer command that closes the open field and
// record. The output channel (out_valid, out_ready, out_data) returns exactly one
// result beat for every input beat, in order: a tagged text byte, a field close with
// its field number and pair separator count, or an all-zero beat for a byte that
// only updates the state (a pair separator, or a repeated field separator).
// The result of an accepted beat is registered into the output buffer. Throughput
// is one beat per cycle while in_ready is high; the field state update and the byte
// classification are combinational logic between the state registers and the buffer.
// The output buffer holds two beats, so in_ready stays high through a stall of the
// receiver while the skid entry is empty; in_ready drops only while both entries are
// occupied and rises again after the receiver takes a beat.
// Configuration (cfg_we, cfg_index, cfg_data) is written in one cycle with no
// handshake and should change only while the block is idle.
// Synchronous reset restores the separator defaults (comma, equals sign, newline,
// no collapsing), clears the field state and empties the output buffer.
`timescale 1ns / 1ps
`default_nettype none

module key_value_pair_tokenizer #(
  parameter int FIELD_NUMBER_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire kvt_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output kvt_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_we,
  input  wire logic [kvt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [kvt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // The field counter saturates at the smaller of its own range and the width of
  // the field number on the result beat, so it never needs more bits than that.
  localparam int CNT_BITS = (FIELD_NUMBER_BITS < kvt_pkg::FIELD_NUMBER_OUT_BITS)
                          ? FIELD_NUMBER_BITS : kvt_pkg::FIELD_NUMBER_OUT_BITS;

  kvt_pkg::cfg_t      cfg;
  kvt_pkg::out_item_t result;
  logic               accept;
  logic               buffer_full;

  // A beat is taken whenever the output buffer has a free entry.
  assign in_ready = !buffer_full;
  assign accept   = in_valid && in_ready;

  kvt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Field state and byte classification; the state advances only on accepted beats.
  kvt_core #(
    .CNT_BITS (CNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // Result register plus one skid entry toward the receiver.
  kvt_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .din       (result),
    .full      (buffer_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : key_value_pair_tokenizer

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the key/value tokenizer (key_value_pair_tokenizer).
// It holds its own model of the field and record state, and it checks every result beat in order.
// Depends on kvt_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
  import kvt_pkg::*;

  localparam int FIELD_NUMBER_BITS = 16;
  // The field number saturates at the smaller of the counter range and the 16-bit output.
  localparam logic [15:0] FIELD_LIMIT =
    (FIELD_NUMBER_BITS >= 16) ? 16'hFFFF : 16'((1 << FIELD_NUMBER_BITS) - 1);
  localparam logic CMD_DATA_BYTE = ~CMD_END_OF_BUFFER;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_PRINTED = 50;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // Idle rates of the two sides, in percent of cycles.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned cycle_count;

  // Expected result beats, oldest first.
  out_item_t expected_results[$];

  // Our copy of the configuration registers and of the tokenizer state.
  cfg_t tokenizer_cfg;
  logic [15:0] fields_closed;
  logic [1:0] pair_seps_open;
  bit key_text_seen;
  bit skip_field_seps;

  key_value_pair_tokenizer #(
    .FIELD_NUMBER_BITS(FIELD_NUMBER_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog. A correct run finishes far below this limit, so reaching it means
  // a handshake has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls at random. With a zero rate, ready stays high.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result beat taken by the receiver is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      check_result(out_data);
    end
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] result %0d: %s is %0h, expected %0h", $time, results_checked, what, got,
               want);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("beat with nothing expected", got, 0);
      return;
    end
    want = expected_results.pop_front();
    if (got.text_valid !== want.text_valid)
      report_mismatch("text_valid", got.text_valid, want.text_valid);
    if (got.text_byte !== want.text_byte)
      report_mismatch("text_byte", got.text_byte, want.text_byte);
    if (got.segment !== want.segment)
      report_mismatch("segment", got.segment, want.segment);
    if (got.field_end !== want.field_end)
      report_mismatch("field_end", got.field_end, want.field_end);
    if (got.field_number !== want.field_number)
      report_mismatch("field_number", got.field_number, want.field_number);
    if (got.pair_seps_seen !== want.pair_seps_seen)
      report_mismatch("pair_seps_seen", got.pair_seps_seen, want.pair_seps_seen);
    if (got.record_end !== want.record_end)
      report_mismatch("record_end", got.record_end, want.record_end);
    if (got.empty_key_error !== want.empty_key_error)
      report_mismatch("empty_key_error", got.empty_key_error, want.empty_key_error);
    results_checked++;
  endtask

  // Closing a field reports its number, its pair separator count and whether the
  // key segment stayed empty, then starts a fresh field.
  function automatic void close_open_field(inout out_item_t res);
    if (fields_closed < FIELD_LIMIT) fields_closed++;
    res.field_end = 1'b1;
    res.field_number = fields_closed;
    res.pair_seps_seen = pair_seps_open;
    res.empty_key_error = !key_text_seen;
    pair_seps_open = 2'd0;
    key_text_seen = 1'b0;
  endfunction

  // Works out the result of one input beat and advances our copy of the state.
  // Record end wins over field separator, which wins over pair separator.
  function automatic out_item_t tokenize_beat(in_item_t beat);
    out_item_t res;
    res = '0;
    if (beat.cmd == CMD_END_OF_BUFFER || beat.data_byte == tokenizer_cfg.record_sep) begin
      close_open_field(res);
      res.record_end = 1'b1;
      fields_closed = '0;
      skip_field_seps = 1'b0;
    end else if (beat.data_byte == tokenizer_cfg.field_sep) begin
      // A separator that follows a separator is swallowed while collapsing is on.
      if (!skip_field_seps) begin
        close_open_field(res);
        skip_field_seps = tokenizer_cfg.collapse_repeats;
      end
    end else if (beat.data_byte == tokenizer_cfg.pair_sep) begin
      skip_field_seps = 1'b0;
      if (pair_seps_open != 2'd3) pair_seps_open++;
    end else begin
      skip_field_seps = 1'b0;
      if (pair_seps_open == 2'd0) key_text_seen = 1'b1;
      res.text_valid = 1'b1;
      res.text_byte = beat.data_byte;
      res.segment = pair_seps_open;
    end
    return res;
  endfunction

  // Sends one input beat. Valid is raised after an optional random gap and held
  // until the beat is taken; the expectation is recorded at the accepting edge.
  task automatic send_beat(logic cmd, logic [7:0] data_byte);
    in_item_t beat;
    beat.cmd = cmd;
    beat.data_byte = data_byte;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(tokenize_beat(beat));
    beats_sent++;
  endtask

  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++) begin
      send_beat(CMD_DATA_BYTE, text[i]);
    end
  endtask

  // The sender holds off until every outstanding result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      CFG_FIELD_SEP: tokenizer_cfg.field_sep = value;
      CFG_PAIR_SEP: tokenizer_cfg.pair_sep = value;
      CFG_RECORD_SEP: tokenizer_cfg.record_sep = value;
      CFG_COLLAPSE_REPEATS: tokenizer_cfg.collapse_repeats = value[0];
      default: ;
    endcase
  endtask

  // Registers change only once the block has drained, so no beat in flight sees
  // a half-written configuration.
  task automatic apply_config(logic [7:0] field_sep, logic [7:0] pair_sep,
                              logic [7:0] record_sep, logic collapse);
    wait_for_results();
    write_reg(CFG_FIELD_SEP, field_sep);
    write_reg(CFG_PAIR_SEP, pair_sep);
    write_reg(CFG_RECORD_SEP, record_sep);
    write_reg(CFG_COLLAPSE_REPEATS, {7'd0, collapse});
    cfg_we <= 1'b0;
  endtask

  // Separator values lean toward the extremes of the byte range.
  function automatic logic [7:0] pick_sep_value();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly distinct separators; now and then they are left to coincide.
  task automatic apply_random_config();
    logic [7:0] field_sep;
    logic [7:0] pair_sep;
    logic [7:0] record_sep;
    field_sep = pick_sep_value();
    pair_sep = pick_sep_value();
    record_sep = pick_sep_value();
    if ($urandom_range(99) < 80) begin
      while (pair_sep == field_sep) pair_sep = pick_sep_value();
      while (record_sep == field_sep || record_sep == pair_sep) record_sep = pick_sep_value();
    end
    apply_config(field_sep, pair_sep, record_sep, 1'($urandom_range(1)));
  endtask

  // Any byte that the current configuration treats as plain text.
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == tokenizer_cfg.field_sep || b == tokenizer_cfg.pair_sep ||
               b == tokenizer_cfg.record_sep);
    return b;
  endfunction

  // One record of key/value fields with random content, or a short burst of raw
  // beats. Keys may be empty, fields may be positional or carry several pair
  // separators, separators may repeat, and a record may be left open.
  task automatic send_random_record();
    int unsigned n_fields;
    int unsigned n_pairs;
    int unsigned pick;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) begin
        send_beat(($urandom_range(99) < 25) ? CMD_END_OF_BUFFER : CMD_DATA_BYTE,
                  8'($urandom));
      end
      return;
    end
    n_fields = $urandom_range(0, 5);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) begin
        send_beat(CMD_DATA_BYTE, tokenizer_cfg.field_sep);
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(1, 3)) send_beat(CMD_DATA_BYTE, tokenizer_cfg.field_sep);
        end
      end
      repeat ($urandom_range(0, 3)) send_beat(CMD_DATA_BYTE, pick_text_byte());
      pick = $urandom_range(99);
      n_pairs = (pick < 30) ? 0 : (pick < 80) ? 1 : $urandom_range(2, 5);
      repeat (n_pairs) begin
        send_beat(CMD_DATA_BYTE, tokenizer_cfg.pair_sep);
        repeat ($urandom_range(0, 3)) send_beat(CMD_DATA_BYTE, pick_text_byte());
      end
    end
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_beat(CMD_DATA_BYTE, tokenizer_cfg.record_sep);
    end else if (pick < 90) begin
      send_beat(CMD_END_OF_BUFFER, 8'($urandom));
    end
  endtask

  // Reset separators: key/value fields, an empty key, pair separator saturation,
  // the zero byte and 0xFF as text, record end, and end of buffer with a data
  // byte that would otherwise be a separator.
  task automatic test_default_separators();
    send_text("k=v,=x,a====b");
    send_beat(CMD_DATA_BYTE, 8'h00);
    send_beat(CMD_DATA_BYTE, 8'hFF);
    send_text("\n");
    send_beat(CMD_END_OF_BUFFER, 8'hFF);
    send_beat(CMD_END_OF_BUFFER, ",");
  endtask

  // Runs of field separators are swallowed, and an empty field after a skipped
  // run still reports its empty key.
  task automatic test_collapsed_separators();
    apply_config(",", "=", "\n", 1'b1);
    send_text(",,a,,=b\n");
  endtask

  // When separator values coincide, record end beats field, and field beats pair.
  task automatic test_coinciding_separators();
    apply_config(";", ";", ";", 1'b0);
    send_text("a;");
    apply_config(":", ":", "\n", 1'b0);
    send_text("a:b\n");
    apply_config(",", "|", "|", 1'b1);
    send_text("a|");
  endtask

  // Separators at both ends of the byte range.
  task automatic test_extreme_separators();
    apply_config(8'h00, 8'hFF, 8'h80, 1'b0);
    send_beat(CMD_DATA_BYTE, "a");
    send_beat(CMD_DATA_BYTE, 8'hFF);
    send_beat(CMD_DATA_BYTE, 8'h00);
    send_beat(CMD_DATA_BYTE, 8'h80);
    apply_config(8'hFF, 8'h80, 8'h00, 1'b1);
    send_beat(CMD_DATA_BYTE, "a");
    send_beat(CMD_DATA_BYTE, 8'h80);
    send_beat(CMD_DATA_BYTE, 8'hFF);
    send_beat(CMD_DATA_BYTE, 8'hFF);
    send_beat(CMD_DATA_BYTE, 8'h00);
  endtask

  // A long record of empty fields counts up one by one, then a fresh record
  // must count from one again.
  task automatic test_field_numbering();
    apply_config(",", "=", "\n", 1'b0);
    send_text("a");
    repeat (40) send_beat(CMD_DATA_BYTE, ",");
    send_text("\nb\n");
  endtask

  // Random records under random configurations, with occasional hold-offs of the
  // sender and reconfiguration between records.
  task automatic test_random_records(int unsigned count);
    int unsigned stop_at;
    stop_at = beats_sent + count;
    apply_random_config();
    while (beats_sent < stop_at) begin
      send_random_record();
      if ($urandom_range(99) < 4) wait_for_results();
      if ($urandom_range(99) < 3) apply_random_config();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 10;
    recv_stall_pct = 49;
    beats_sent = 0;
    results_checked = 0;
    mismatches = 0;
    cycle_count = 0;
    tokenizer_cfg.field_sep = FIELD_SEP_RESET;
    tokenizer_cfg.pair_sep = PAIR_SEP_RESET;
    tokenizer_cfg.record_sep = RECORD_SEP_RESET;
    tokenizer_cfg.collapse_repeats = COLLAPSE_REPEATS_RESET;
    fields_closed = '0;
    pair_seps_open = 2'd0;
    key_text_seen = 1'b0;
    skip_field_seps = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Light sender gaps, heavy receiver stalls.
    test_default_separators();
    test_collapsed_separators();
    test_coinciding_separators();
    test_random_records(430);

    // Heavy sender gaps, light receiver stalls.
    send_idle_pct = 49;
    recv_stall_pct = 10;
    test_extreme_separators();
    test_random_records(430);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_field_numbering();
    test_random_records(430);

    // Drain, then leave time for any stray beat to show up.
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/kvt_pkg.sv
rtl/kvt_cfg.sv
rtl/kvt_core.sv
rtl/kvt_skid.sv
rtl/key_value_pair_tokenizer.sv
test/testbench.sv
